FILE: hdl/gpwsm_pkg.sv
// Shared types, constants and the Beaufort lookup for the pulse wind speed meter.
`default_nettype none

package gpwsm_pkg;

	localparam int PROD_W    = 50;
	localparam int DEN_W     = 48;
	localparam int QUO_W     = 18;
	localparam int SPEED_W   = 16;
	localparam int CONV_W    = 18;
	localparam int STEP_W    = 5;
	localparam int BFT_N     = 11;
	localparam int KMH_SHIFT = 19;
	localparam int MPH_SHIFT = 28;

	localparam logic [STEP_W-1:0] SPD_STEPS_M1 = 5'd15;

	localparam logic [17:0] NUM_SCALE = 18'd1000;

	// floor(speed*3.6) and floor(speed*2.23694) as multiply and shift, exact for 16-bit speeds
	localparam logic [31:0] KMH_RECIP = 32'd1887437;    // ceil(3.6 * 2^19)
	localparam logic [31:0] MPH_RECIP = 32'd600474009;  // ceil(2.23694 * 2^28)

	localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

	localparam logic REG_CAL = 1'b0;
	localparam logic REG_WIN = 1'b1;

	localparam logic [CONV_W-1:0] BFT_THRESH [BFT_N] = '{
		18'd256, 18'd1280, 18'd3072, 18'd5120, 18'd7424, 18'd9984,
		18'd12800, 18'd15872, 18'd19200, 18'd22784, 18'd26368
	};

	typedef enum logic [1:0] {
		CMD_PULSE = 2'd0,
		CMD_CALC  = 2'd1,
		CMD_RESET = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_DEN,
		ST_MUL_NUM,
		ST_CHECK,
		ST_DIV_SPD,
		ST_SPD_WB,
		ST_MUL_KMH,
		ST_KMH_WB,
		ST_MPH_WB,
		ST_DONE
	} st_t;

	typedef enum logic [1:0] {
		MUL_DEN,
		MUL_NUM,
		MUL_KMH,
		MUL_MPH
	} mul_sel_t;

	typedef enum logic [1:0] {
		DP_IDLE,
		DP_LOAD_DEN,
		DP_LOAD_NUM,
		DP_STEP
	} dp_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		dp_op_t   op;
	} dp_ctrl_t;

	typedef struct packed {
		logic              num_ge_den;
		logic [QUO_W-1:0]  quo;
		logic [CONV_W-1:0] kmh;
		logic [CONV_W-1:0] mph;
	} dp_stat_t;

	// thresholds rise monotonically, so the class is the number passed
	function automatic logic [3:0] beaufort_of(input logic [CONV_W-1:0] kmh);
		logic [3:0] cls;
		cls = '0;
		for (int i = 0; i < BFT_N; i++) begin
			if (kmh >= BFT_THRESH[i]) begin
				cls = cls + 4'd1;
			end
		end
		return cls;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/gpwsm_dp.sv
// Shared multiplier and restoring divide step used by the speed sequencer.
`default_nettype none

module gpwsm_dp
	import gpwsm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_ctrl_t            ctrl,
	input  wire logic [31:0]         elapsed,
	input  wire logic [15:0]         cal,
	input  wire logic [31:0]         count,
	input  wire logic [SPEED_W-1:0]  speed,
	output dp_stat_t                 stat
);

	logic [31:0]       mul_a;
	logic [17:0]       mul_b;
	logic [PROD_W-1:0] prod_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  dvs_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DEN_W:0]    sub_a;
	logic [DEN_W+1:0]  diff;
	logic              ge;

	always_comb begin
		case (ctrl.mul_sel)
			MUL_DEN: begin
				mul_a = elapsed;
				mul_b = 18'(cal);
			end
			MUL_NUM: begin
				mul_a = count;
				mul_b = NUM_SCALE;
			end
			MUL_KMH: begin
				mul_a = KMH_RECIP;
				mul_b = 18'(speed);
			end
			MUL_MPH: begin
				mul_a = MPH_RECIP;
				mul_b = 18'(speed);
			end
			default: begin
				mul_a = elapsed;
				mul_b = 18'(cal);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// one subtractor: saturation compare on load, trial subtract on each step
	assign sub_a = (ctrl.op == DP_LOAD_NUM) ? {1'b0, prod_q[DEN_W-1:0]}
	                                       : {rem_q, 1'b0};
	assign diff  = {1'b0, sub_a} - {2'b00, dvs_q};
	assign ge    = ~diff[DEN_W+1];

	always_ff @(posedge clk) begin
		case (ctrl.op)
			DP_LOAD_DEN: begin
				dvs_q <= prod_q[DEN_W-1:0];
			end
			DP_LOAD_NUM: begin
				rem_q <= prod_q[DEN_W-1:0];
				quo_q <= '0;
			end
			DP_STEP: begin
				if (ge) begin
					rem_q <= diff[DEN_W-1:0];
				end else begin
					rem_q <= sub_a[DEN_W-1:0];
				end
				quo_q <= {quo_q[QUO_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign stat.num_ge_den = ge;
	assign stat.quo        = quo_q;
	assign stat.kmh        = prod_q[KMH_SHIFT+CONV_W-1:KMH_SHIFT];
	assign stat.mph        = prod_q[MPH_SHIFT+CONV_W-1:MPH_SHIFT];

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == DP_STEP |-> rem_q < dvs_q)
		else $error("remainder not below divisor during divide step");

	a_kmh_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mul_sel == MUL_KMH |=> prod_q[PROD_W-1:KMH_SHIFT+CONV_W] == '0)
		else $error("km/h product wider than expected");

	a_mph_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mul_sel == MUL_MPH |=> prod_q[PROD_W-1:MPH_SHIFT+CONV_W] == '0)
		else $error("mph product wider than expected");

endmodule

`default_nettype wire

FILE: hdl/gated_pulse_wind_speed_meter.sv
// Top level of the gated pulse wind speed meter: stream ports, registers, sequencer.
// Each input beat carries a command in s_tuser (pulse edge, calculate, reset count and window)
// and the millisecond time in s_tdata. A pulse edge, a reset, an unknown command and a calculate
// that comes before the window has run are all handled without the sequencer and give their result beat on
// the next edge. A calculate that closes the window starts the speed sequence on one 32x18
// multiplier and one 49-bit restoring divide step: two products form the divisor and the
// scaled count, a compare catches saturation and an empty count, 16 divide steps give the
// speed quotient, and km/h and mph come from two more products by fixed reciprocals. The divide
// steps are skipped when the speed saturates or no pulses were counted; s_tready stays low
// throughout the sequence. A result beat that waits unaccepted also holds
// s_tready low, except in the cycle in which it is taken.
// The Beaufort class follows from the km/h value against fixed thresholds.
`default_nettype none

module gated_pulse_wind_speed_meter
	import gpwsm_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] time_ms
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [15:0] speed_ms_q8, [33:16] speed_kmh_q8,
	                                    // [51:34] speed_mph_q8, [55:52] beaufort_class,
	                                    // [79:56] pulse_total
	output logic             m_tuser,   // [0] updated
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	st_t                    state_q, state_d;
	logic [STEP_W-1:0]      step_q;
	logic [COUNT_BITS-1:0]  pulse_cnt_q;
	logic [COUNT_BITS-1:0]  cnt_inc;
	logic [COUNT_BITS-1:0]  cnt_after;
	logic [31:0]            count_ext;
	logic [31:0]            start_q;
	logic [31:0]            now_q;
	logic [31:0]            elapsed_q;
	logic [31:0]            elapsed_w;
	logic [SPEED_W-1:0]     speed_q;
	logic [CONV_W-1:0]      kmh_q;
	logic [CONV_W-1:0]      mph_q;
	logic [15:0]            cal_q;
	logic [15:0]            win_q;
	logic                   m_valid_q;
	logic [79:0]            out_data_q;
	logic                   out_upd_q;
	logic                   out_free;
	logic                   in_fire;
	logic                   calc_due;
	logic                   imm_load;
	logic                   done_fire;
	logic                   cnt_zero;
	logic                   cfg_wr;
	logic [3:0]             cls_now;
	dp_ctrl_t               dp_ctrl;
	dp_stat_t               dp_stat;

	assign out_free  = ~m_valid_q | m_tready;
	assign in_fire   = s_tvalid & s_tready;
	assign elapsed_w = s_tdata - start_q;
	assign calc_due  = elapsed_w >= 32'(win_q);
	assign imm_load  = in_fire & ~((s_tuser == CMD_CALC) & calc_due);
	assign cnt_zero  = pulse_cnt_q == '0;
	assign cnt_inc   = (pulse_cnt_q == {COUNT_BITS{1'b1}}) ? pulse_cnt_q
	                                                        : pulse_cnt_q + COUNT_BITS'(1);
	assign count_ext = 32'(cnt_after);
	assign cls_now   = beaufort_of(kmh_q);

	always_comb begin
		case (s_tuser)
			CMD_PULSE: cnt_after = cnt_inc;
			CMD_RESET: cnt_after = '0;
			default:   cnt_after = pulse_cnt_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && s_tuser == CMD_CALC && calc_due) begin
					state_d = ST_MUL_DEN;
				end
			end
			ST_MUL_DEN: state_d = ST_MUL_NUM;
			ST_MUL_NUM: state_d = ST_CHECK;
			ST_CHECK: begin
				if (cnt_zero || dp_stat.num_ge_den) begin
					state_d = ST_MUL_KMH;
				end else begin
					state_d = ST_DIV_SPD;
				end
			end
			ST_DIV_SPD: begin
				if (step_q == '0) begin
					state_d = ST_SPD_WB;
				end
			end
			ST_SPD_WB:  state_d = ST_MUL_KMH;
			ST_MUL_KMH: state_d = ST_KMH_WB;
			ST_KMH_WB:  state_d = ST_MPH_WB;
			ST_MPH_WB:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready        = 1'b0;
		done_fire       = 1'b0;
		dp_ctrl.mul_sel = MUL_DEN;
		dp_ctrl.op      = DP_IDLE;
		case (state_q)
			ST_IDLE:    s_tready = out_free;
			ST_MUL_DEN: dp_ctrl.mul_sel = MUL_DEN;
			ST_MUL_NUM: begin
				dp_ctrl.mul_sel = MUL_NUM;
				dp_ctrl.op      = DP_LOAD_DEN;
			end
			ST_CHECK:   dp_ctrl.op = DP_LOAD_NUM;
			ST_DIV_SPD: dp_ctrl.op = DP_STEP;
			ST_MUL_KMH: dp_ctrl.mul_sel = MUL_KMH;
			ST_KMH_WB:  dp_ctrl.mul_sel = MUL_MPH;
			ST_DONE:    done_fire = out_free;
			default: begin
			end
		endcase
	end

	gpwsm_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (dp_ctrl),
		.elapsed (elapsed_q),
		.cal     (cal_q),
		.count   (32'(pulse_cnt_q)),
		.speed   (speed_q),
		.stat    (dp_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			case (state_q)
				ST_CHECK:   step_q <= SPD_STEPS_M1;
				ST_DIV_SPD: step_q <= step_q - STEP_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_cnt_q <= '0;
			start_q     <= '0;
		end else if (done_fire) begin
			pulse_cnt_q <= '0;
			start_q     <= now_q;
		end else if (in_fire) begin
			pulse_cnt_q <= cnt_after;
			if (s_tuser == CMD_RESET) begin
				start_q <= s_tdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_tuser == CMD_CALC && calc_due) begin
			now_q     <= s_tdata;
			elapsed_q <= elapsed_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			kmh_q   <= '0;
			mph_q   <= '0;
		end else begin
			case (state_q)
				ST_CHECK: begin
					if (cnt_zero) begin
						speed_q <= '0;
					end else if (dp_stat.num_ge_den) begin
						speed_q <= SPEED_MAX;
					end
				end
				ST_SPD_WB: speed_q <= dp_stat.quo[SPEED_W-1:0];
				ST_KMH_WB: kmh_q   <= dp_stat.kmh;
				ST_MPH_WB: mph_q   <= dp_stat.mph;
				default: begin
				end
			endcase
		end
	end

	// configuration
	assign cfg_wr = psel & penable & pwrite & pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WIN) ? 32'(win_q) : 32'(cal_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= 16'd256;
			win_q <= 16'd1000;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_CAL) begin
				cal_q <= pwdata[15:0];
			end else begin
				win_q <= pwdata[15:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (imm_load || done_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (imm_load) begin
			out_data_q <= {count_ext[23:0], cls_now, mph_q, kmh_q, speed_q};
			out_upd_q  <= 1'b0;
		end else if (done_fire) begin
			out_data_q <= {24'd0, cls_now, mph_q, kmh_q, speed_q};
			out_upd_q  <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_upd_q;

	a_quo_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SPD_WB |-> dp_stat.quo[QUO_W-1:SPEED_W] == '0)
		else $error("speed quotient exceeds 16 bits after saturation check");

	a_conv_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> mph_q <= kmh_q)
		else $error("mph value above km/h value");

	a_upd_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[79:56] == '0)
		else $error("updated result carries a nonzero pulse count");

endmodule

`default_nettype wire
